FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the line rasterizer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside of reset.
`define CLR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("clipped_line_rasterizer: assertion failed");

// Expression must never be true at a rising edge outside of reset.
`define CLR_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("clipped_line_rasterizer: forbidden condition seen");

`endif

FILE: rtl/core/clr_pkg.sv
// ----------------------------------------------------------------------------
// clr_pkg
// Shared types and constants of the clipped line rasterizer.
// ----------------------------------------------------------------------------
package clr_pkg;

   // Operation codes carried in the request kind field.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   // Register indexes of the write port.
   localparam int unsigned CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SURFACE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SURFACE_HEIGHT = 1'b1;

   // Fixed field widths.
   localparam int unsigned SURF_BITS   = 13;
   localparam int unsigned ADDR_BITS   = 24;
   localparam int unsigned COLOUR_BITS = 32;

   // Surface size after reset.
   localparam logic [SURF_BITS-1:0] SURF_WIDTH_RESET  = 13'd640;
   localparam logic [SURF_BITS-1:0] SURF_HEIGHT_RESET = 13'd480;

   // Surface size as seen by the pixel generator.
   typedef struct packed {
      logic [SURF_BITS-1:0] width;
      logic [SURF_BITS-1:0] height;
   } surf_cfg_type;

endpackage

FILE: rtl/core/clr_line_core.sv
// ----------------------------------------------------------------------------
// clr_line_core
// Line state registers with the load setup and the per-pixel step logic.
// ----------------------------------------------------------------------------
module clr_line_core #(
   parameter int unsigned COORD_BITS = 13
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic                               op,
   input  logic [COORD_BITS-1:0]              start_x,
   input  logic [COORD_BITS-1:0]              start_y,
   input  logic [COORD_BITS-1:0]              end_x,
   input  logic [COORD_BITS-1:0]              end_y,
   input  logic [clr_pkg::COLOUR_BITS-1:0]    line_colour,
   input  clr_pkg::surf_cfg_type              surf,
   output logic                               res_we,
   output logic                               res_done,
   output logic [COORD_BITS-1:0]              res_x,
   output logic [COORD_BITS-1:0]              res_y,
   output logic [clr_pkg::ADDR_BITS-1:0]      res_addr,
   output logic [clr_pkg::COLOUR_BITS-1:0]    res_value
);

   localparam int unsigned DW = COORD_BITS + 1;
   localparam int unsigned EW = COORD_BITS + 3;
   localparam int unsigned CMP_BITS =
      (COORD_BITS > clr_pkg::SURF_BITS) ? COORD_BITS : clr_pkg::SURF_BITS;
   localparam int unsigned MUL_BITS =
      (COORD_BITS + clr_pkg::SURF_BITS > clr_pkg::ADDR_BITS) ?
      (COORD_BITS + clr_pkg::SURF_BITS) : clr_pkg::ADDR_BITS;

   logic                            line_active_ff, line_active_in;
   logic                            steep_ff, steep_in;
   logic [COORD_BITS-1:0]           major_pos_ff, major_pos_in;
   logic [COORD_BITS-1:0]           major_end_ff, major_end_in;
   logic [COORD_BITS-1:0]           minor_pos_ff, minor_pos_in;
   logic                            minor_neg_ff, minor_neg_in;
   logic [EW-1:0]                   error_ff, error_in;
   logic [DW-1:0]                   major_delta_ff, major_delta_in;
   logic [DW-1:0]                   minor_delta_ff, minor_delta_in;
   logic [clr_pkg::COLOUR_BITS-1:0] colour_ff, colour_in;

   // Load setup.
   logic [DW-1:0]         dx, dy, adx, ady;
   logic                  ld_steep, ld_swap, ld_active;
   logic [COORD_BITS-1:0] a1, a2, b1, b2, maj_lo, maj_hi, min_lo, min_hi;
   logic [DW-1:0]         ld_major_delta, min_diff, ld_minor_delta;

   // Pixel step.
   logic                  run, on_surface, err_neg;
   logic [COORD_BITS-1:0] px, py, major_next;
   logic [EW-1:0]         err_sub;
   logic [MUL_BITS-1:0]   addr_full;

   always_comb begin
      dx  = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
      dy  = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
      adx = dx[DW-1] ? -dx : dx;
      ady = dy[DW-1] ? -dy : dy;
      ld_steep = ady > adx;

      a1 = ld_steep ? start_y : start_x;
      a2 = ld_steep ? end_y   : end_x;
      b1 = ld_steep ? start_x : start_y;
      b2 = ld_steep ? end_x   : end_y;

      // Order the endpoints so that the major coordinate increases.
      ld_swap = $signed(a1) > $signed(a2);
      maj_lo  = ld_swap ? a2 : a1;
      maj_hi  = ld_swap ? a1 : a2;
      min_lo  = ld_swap ? b2 : b1;
      min_hi  = ld_swap ? b1 : b2;

      ld_major_delta = {maj_hi[COORD_BITS-1], maj_hi} - {maj_lo[COORD_BITS-1], maj_lo};
      min_diff       = {min_hi[COORD_BITS-1], min_hi} - {min_lo[COORD_BITS-1], min_lo};
      ld_minor_delta = min_diff[DW-1] ? -min_diff : min_diff;
      ld_active      = $signed(maj_lo) < $signed(maj_hi);
   end

   always_comb begin
      run = line_active_ff && ($signed(major_pos_ff) < $signed(major_end_ff));
      px  = steep_ff ? minor_pos_ff : major_pos_ff;
      py  = steep_ff ? major_pos_ff : minor_pos_ff;

      on_surface = !px[COORD_BITS-1] && !py[COORD_BITS-1] &&
                   (CMP_BITS'(px) < CMP_BITS'(surf.width)) &&
                   (CMP_BITS'(py) < CMP_BITS'(surf.height));

      addr_full = MUL_BITS'(py) * MUL_BITS'(surf.width) + MUL_BITS'(px);

      // Doubled error: drop by twice the minor delta, and when it goes
      // negative move the minor coordinate and add twice the major delta.
      err_sub = error_ff - EW'({minor_delta_ff, 1'b0});
      err_neg = err_sub[EW-1];
      major_next = major_pos_ff + COORD_BITS'(1);
   end

   always_comb begin
      line_active_in = line_active_ff;
      steep_in       = steep_ff;
      major_pos_in   = major_pos_ff;
      major_end_in   = major_end_ff;
      minor_pos_in   = minor_pos_ff;
      minor_neg_in   = minor_neg_ff;
      error_in       = error_ff;
      major_delta_in = major_delta_ff;
      minor_delta_in = minor_delta_ff;
      colour_in      = colour_ff;

      res_we    = 1'b0;
      res_done  = 1'b1;
      res_x     = '0;
      res_y     = '0;
      res_addr  = '0;
      res_value = '0;

      if (op == clr_pkg::OP_LOAD) begin
         line_active_in = ld_active;
         steep_in       = ld_steep;
         major_pos_in   = maj_lo;
         major_end_in   = maj_hi;
         minor_pos_in   = min_lo;
         minor_neg_in   = !($signed(min_lo) < $signed(min_hi));
         error_in       = EW'(ld_major_delta);
         major_delta_in = ld_major_delta;
         minor_delta_in = ld_minor_delta;
         colour_in      = line_colour;
         res_done       = !ld_active;
      end else if (!run) begin
         line_active_in = 1'b0;
      end else begin
         res_x = px;
         res_y = py;
         if (on_surface) begin
            res_we    = 1'b1;
            res_addr  = addr_full[clr_pkg::ADDR_BITS-1:0];
            res_value = colour_ff;
         end
         if (err_neg) begin
            minor_pos_in = minor_pos_ff + (minor_neg_ff ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
            error_in     = err_sub + EW'({major_delta_ff, 1'b0});
         end else begin
            error_in = err_sub;
         end
         major_pos_in   = major_next;
         line_active_in = $signed(major_next) < $signed(major_end_ff);
         res_done       = !line_active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff <= 1'b0;
      end else if (accept) begin
         line_active_ff <= line_active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         steep_ff       <= steep_in;
         major_pos_ff   <= major_pos_in;
         major_end_ff   <= major_end_in;
         minor_pos_ff   <= minor_pos_in;
         minor_neg_ff   <= minor_neg_in;
         error_ff       <= error_in;
         major_delta_ff <= major_delta_in;
         minor_delta_ff <= minor_delta_in;
         colour_ff      <= colour_in;
      end
   end

endmodule

FILE: rtl/core/clr_out_skid.sv
// ----------------------------------------------------------------------------
// clr_out_skid
// Two-entry output buffer: result register plus a skid register.
// ----------------------------------------------------------------------------
module clr_out_skid #(
   parameter int unsigned DATA_BITS = 90
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [DATA_BITS-1:0] in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [DATA_BITS-1:0] out_data
);

   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   logic [DATA_BITS-1:0] out_data_ff, out_data_in;
   logic [DATA_BITS-1:0] skid_data_ff, skid_data_in;
   logic                 push, pop;

   assign in_ready  = !skid_valid_ff && !reset;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      push = in_valid && in_ready;
      pop  = out_valid_ff && out_ready;

      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;

      if (pop) begin
         if (skid_valid_ff) begin
            // The skid entry moves up; the skid is full only when no push.
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_data_in = in_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff) begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end else begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

FILE: rtl/core/clipped_line_rasterizer.sv
// The result of an accepted item is registered in the output buffer and presented on rsp_.
// One load or pixel step per cycle when req_tready is high: a single register-to-register pass.
// The result register plus a skid entry let one more item in while a result waits.
// Reset (synchronous, active high) clears the line, empties the output buffer and
// sets the surface to 640 by 480; req_tready is low while reset is high.
// ----------------------------------------------------------------------------
// clipped_line_rasterizer
// Bresenham line generator with per-pixel clipping against a configurable
// surface, giving a row-major address and colour for every visible pixel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clipped_line_rasterizer #(
   parameter int unsigned COORD_BITS = 13
) (
   input  logic                                   clock,
   input  logic                                   reset,

   // Register write port: index 0 surface width, index 1 surface height.
   input  logic                                   csr_wr_en,
   input  logic [clr_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [clr_pkg::SURF_BITS-1:0]          csr_wdata,

   // Request channel.
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // tdata, lowest bits first: start_x, start_y, end_x, end_y, line_colour, zero pad.
   input  logic [((4*COORD_BITS+32+7)/8)*8-1:0]   req_tdata,
   // tuser: op (0 load a line, 1 step one pixel).
   input  logic                                   req_tuser,

   // Result channel.
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // tdata, lowest bits first: pixel_x, pixel_y, pixel_address, pixel_value, zero pad.
   output logic [((2*COORD_BITS+56+7)/8)*8-1:0]   rsp_tdata,
   // tuser: write_enable.
   output logic                                   rsp_tuser,
   // tlast: line_done.
   output logic                                   rsp_tlast
);

   localparam int unsigned CB            = COORD_BITS;
   localparam int unsigned RSP_DATA_BITS = ((2*COORD_BITS+56+7)/8)*8;
   localparam int unsigned BUF_BITS      = RSP_DATA_BITS + 2;

   // Field positions inside the result word.
   localparam int unsigned RSP_Y_LSB    = CB;
   localparam int unsigned RSP_ADDR_LSB = 2*CB;
   localparam int unsigned RSP_VAL_LSB  = 2*CB + clr_pkg::ADDR_BITS;

   // Surface size registers. The write port has no handshake: a write lands
   // at the edge where csr_wr_en is high.
   clr_pkg::surf_cfg_type surf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         surf_ff.width  <= clr_pkg::SURF_WIDTH_RESET;
         surf_ff.height <= clr_pkg::SURF_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            clr_pkg::CSR_SURFACE_WIDTH:  surf_ff.width  <= csr_wdata;
            clr_pkg::CSR_SURFACE_HEIGHT: surf_ff.height <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Request unpacking.
   logic [CB-1:0]                   in_start_x, in_start_y, in_end_x, in_end_y;
   logic [clr_pkg::COLOUR_BITS-1:0] in_colour;
   logic                            req_accept;

   assign in_start_x = req_tdata[CB-1:0];
   assign in_start_y = req_tdata[2*CB-1:CB];
   assign in_end_x   = req_tdata[3*CB-1:2*CB];
   assign in_end_y   = req_tdata[4*CB-1:3*CB];
   assign in_colour  = req_tdata[4*CB+clr_pkg::COLOUR_BITS-1:4*CB];
   assign req_accept = req_tvalid && req_tready;

   // The line state advances at each accepted item; its result is computed
   // in the same cycle and captured by the output buffer.
   logic                            res_we, res_done;
   logic [CB-1:0]                   res_x, res_y;
   logic [clr_pkg::ADDR_BITS-1:0]   res_addr;
   logic [clr_pkg::COLOUR_BITS-1:0] res_value;

   clr_line_core #(
      .COORD_BITS (COORD_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .op          (req_tuser),
      .start_x     (in_start_x),
      .start_y     (in_start_y),
      .end_x       (in_end_x),
      .end_y       (in_end_y),
      .line_colour (in_colour),
      .surf        (surf_ff),
      .res_we      (res_we),
      .res_done    (res_done),
      .res_x       (res_x),
      .res_y       (res_y),
      .res_addr    (res_addr),
      .res_value   (res_value)
   );

   // Result packing: line_done and write_enable ride above the data word.
   logic [RSP_DATA_BITS-1:0] res_data;
   logic [BUF_BITS-1:0]      buf_in, buf_out;

   assign res_data = RSP_DATA_BITS'({res_value, res_addr, res_y, res_x});
   assign buf_in   = {res_done, res_we, res_data};

   clr_out_skid #(
      .DATA_BITS (BUF_BITS)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (buf_in),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (buf_out)
   );

   assign rsp_tdata = buf_out[RSP_DATA_BITS-1:0];
   assign rsp_tuser = buf_out[RSP_DATA_BITS];
   assign rsp_tlast = buf_out[RSP_DATA_BITS+1];

   // Views of the presented pixel, used by the checks below.
   logic [CB-1:0] rsp_x, rsp_y;
   logic          load_accept, rsp_neg_pixel, rsp_addr_val_set;

   assign rsp_x            = rsp_tdata[RSP_Y_LSB-1:0];
   assign rsp_y            = rsp_tdata[RSP_ADDR_LSB-1:RSP_Y_LSB];
   assign load_accept      = req_accept && (req_tuser == clr_pkg::OP_LOAD);
   assign rsp_neg_pixel    = rsp_x[CB-1] || rsp_y[CB-1];
   assign rsp_addr_val_set =
      rsp_tdata[RSP_VAL_LSB+clr_pkg::COLOUR_BITS-1:RSP_ADDR_LSB] != '0;

   // A loading item never produces a pixel write.
   `CLR_ASSERT(a_load_no_write, clock, reset, load_accept |-> !res_we)

   // After every accepted item, rsp_tvalid is high in the next cycle.
   `CLR_ASSERT(a_accept_gives_result, clock, reset, req_accept |=> rsp_tvalid)

   // A pixel with a negative coordinate must always be clipped.
   `CLR_ASSERT_NEVER(a_no_negative_write, clock, reset, rsp_tvalid && rsp_tuser && rsp_neg_pixel)

   // A result that writes nothing carries a zero address and a zero pixel value.
   `CLR_ASSERT_NEVER(a_nowrite_zero_fields, clock, reset, rsp_tvalid && !rsp_tuser && rsp_addr_val_set)

endmodule

FILE: dv/clipped_line_rasterizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_line_rasterizer_tb
// Streams line loads and pixel steps into the rasterizer, with random gaps on
// the request side and random stalls on the result side. Every accepted item
// is run through a local line-walk predictor. Each result is checked field by
// field against the oldest prediction. The run covers several surface sizes,
// including zero and the largest values the width and height registers hold.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer_tb;

   localparam int COORD_W     = 13;
   localparam int SURF_W      = clr_pkg::SURF_BITS;
   localparam int REQ_W       = ((4*COORD_W+32+7)/8)*8;
   localparam int RSP_W       = ((2*COORD_W+56+7)/8)*8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 230;
   localparam int NUM_SURFS   = 8;

   // One request item as the sender sees it.
   typedef struct {
      logic               op;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic [31:0]        colour;
   } raster_cmd_type;

   // One result item, split into its fields.
   typedef struct {
      logic               write_enable;
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [23:0]        pixel_address;
      logic [31:0]        pixel_value;
      logic               line_done;
   } pixel_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                  csr_wr_en  = 1'b0;
   logic [clr_pkg::CSR_INDEX_BITS-1:0]    csr_index  = clr_pkg::CSR_SURFACE_WIDTH;
   logic [SURF_W-1:0]                     csr_wdata  = '0;

   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   // tdata, lowest bits first: start_x, start_y, end_x, end_y, line_colour, zero pad.
   logic [REQ_W-1:0]              req_tdata  = '0;
   // tuser: op.
   logic                          req_tuser  = clr_pkg::OP_LOAD;

   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   // tdata, lowest bits first: pixel_x, pixel_y, pixel_address, pixel_value, zero pad.
   logic [RSP_W-1:0]              rsp_tdata;
   // tuser: write_enable.
   logic                          rsp_tuser;
   // tlast: line_done.
   logic                          rsp_tlast;

   clipped_line_rasterizer #(
      .COORD_BITS (COORD_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Items waiting to be sent, and the pixels predicted for accepted items.
   raster_cmd_type pending_cmds[$];
   pixel_out_type  expected_pixels[$];
   int             fail_count  = 0;
   int             cycle_count = 0;

   // Surface size as the block holds it. It only changes while nothing is in
   // flight, so the predictor can read it at the moment an item is accepted.
   logic [SURF_W-1:0] surf_w = clr_pkg::SURF_WIDTH_RESET;
   logic [SURF_W-1:0] surf_h = clr_pkg::SURF_HEIGHT_RESET;

   // Line-walk state of the predictor. Coordinates are kept as plain ints;
   // the walk never leaves the 13-bit range except through the minor wrap.
   bit          line_on    = 1'b0;
   bit          steep      = 1'b0;
   bit          minor_down = 1'b0;
   int          major_pos  = 0;
   int          major_stop = 0;
   int          minor_pos  = 0;
   int          walk_error = 0;
   int          major_d    = 0;
   int          minor_d    = 0;
   logic [31:0] held_colour = '0;

   function automatic int to_coord(logic [COORD_W-1:0] bits);
      return int'($signed(bits));
   endfunction

   function automatic int clamp_coord(int v);
      if (v < -4096) return -4096;
      if (v > 4095) return 4095;
      return v;
   endfunction

   // Works out the result of one accepted item and advances the line walk.
   function automatic pixel_out_type rasterize(raster_cmd_type cmd);
      pixel_out_type r;
      int x1, y1, x2, y2, t, adx, ady, px, py;
      logic [63:0] flat;
      logic [COORD_W-1:0] wrapped;
      r = '{default: '0};
      if (cmd.op == clr_pkg::OP_LOAD) begin
         x1 = to_coord(cmd.start_x);
         y1 = to_coord(cmd.start_y);
         x2 = to_coord(cmd.end_x);
         y2 = to_coord(cmd.end_y);
         adx = (x2 > x1) ? x2 - x1 : x1 - x2;
         ady = (y2 > y1) ? y2 - y1 : y1 - y2;
         // A steep line walks along y, so swap the axes first.
         steep = (ady > adx);
         if (steep) begin
            t = x1; x1 = y1; y1 = t;
            t = x2; x2 = y2; y2 = t;
         end
         // Walk with the major coordinate increasing.
         if (x1 > x2) begin
            t = x1; x1 = x2; x2 = t;
            t = y1; y1 = y2; y2 = t;
         end
         major_d     = x2 - x1;
         minor_d     = (y2 > y1) ? y2 - y1 : y1 - y2;
         walk_error  = major_d;
         minor_down  = !(y1 < y2);
         minor_pos   = y1;
         major_pos   = x1;
         major_stop  = x2;
         held_colour = cmd.colour;
         line_on     = (major_pos < major_stop);
         r.line_done = !line_on;
      end else if (!line_on || major_pos >= major_stop) begin
         // Nothing left to draw: an idle result with line_done set.
         line_on     = 1'b0;
         r.line_done = 1'b1;
      end else begin
         px = steep ? minor_pos : major_pos;
         py = steep ? major_pos : minor_pos;
         r.pixel_x = px[COORD_W-1:0];
         r.pixel_y = py[COORD_W-1:0];
         if (px >= 0 && py >= 0 && px < int'(surf_w) && py < int'(surf_h)) begin
            flat = longint'(py) * longint'(surf_w) + longint'(px);
            r.write_enable  = 1'b1;
            r.pixel_address = flat[23:0];
            r.pixel_value   = held_colour;
         end
         walk_error -= 2 * minor_d;
         if (walk_error < 0) begin
            wrapped   = COORD_W'(minor_pos + (minor_down ? -1 : 1));
            minor_pos = to_coord(wrapped);
            walk_error += 2 * major_d;
         end
         major_pos  += 1;
         line_on     = (major_pos < major_stop);
         r.line_done = !line_on;
      end
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Request driver. Before each item it waits a random number of cycles;
   // now and then it switches into a calm mode that sends back to back.
   bit             drv_busy = 1'b0;
   bit             drv_calm = 1'b0;
   int             drv_wait = 0;
   raster_cmd_type drv_cmd  = '{default: '0};

   always @(posedge clock) begin : cmd_driver
      if (reset) begin
         req_tvalid <= 1'b0;
         drv_busy = 1'b0;
         drv_wait = 0;
      end else begin
         if (drv_busy && req_tready) begin
            expected_pixels.push_back(rasterize(drv_cmd));
            drv_busy = 1'b0;
            if ($urandom_range(0, 99) < 4) drv_calm = !drv_calm;
            drv_wait = drv_calm ? 0 : $urandom_range(0, 10);
         end
         if (!drv_busy) begin
            if (drv_wait > 0) begin
               drv_wait--;
            end else if (pending_cmds.size() != 0) begin
               drv_cmd  = pending_cmds.pop_front();
               drv_busy = 1'b1;
            end
         end
         req_tvalid <= drv_busy;
         req_tuser  <= drv_cmd.op;
         req_tdata  <= REQ_W'({drv_cmd.colour, drv_cmd.end_y, drv_cmd.end_x,
                               drv_cmd.start_y, drv_cmd.start_x});
      end
   end

   // Result monitor. After each accepted item it holds tready low for a random
   // number of cycles, with calm stretches where it never stalls.
   bit rsp_calm = 1'b0;
   int rsp_wait = 0;

   always @(posedge clock) begin : pixel_monitor
      pixel_out_type got;
      pixel_out_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.write_enable  = rsp_tuser;
            got.pixel_x       = rsp_tdata[0 +: COORD_W];
            got.pixel_y       = rsp_tdata[COORD_W +: COORD_W];
            got.pixel_address = rsp_tdata[2*COORD_W +: 24];
            got.pixel_value   = rsp_tdata[2*COORD_W+24 +: 32];
            got.line_done     = rsp_tlast;
            if (expected_pixels.size() == 0) begin
               $display("%0t: result with nothing expected, x 0x%0h y 0x%0h done %0b",
                        $time, got.pixel_x, got.pixel_y, got.line_done);
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("write_enable", 32'(want.write_enable), 32'(got.write_enable));
               check_field("pixel_x", 32'(want.pixel_x), 32'(got.pixel_x));
               check_field("pixel_y", 32'(want.pixel_y), 32'(got.pixel_y));
               check_field("pixel_address", 32'(want.pixel_address),
                           32'(got.pixel_address));
               check_field("pixel_value", want.pixel_value, got.pixel_value);
               check_field("line_done", 32'(want.line_done), 32'(got.line_done));
            end
            if ($urandom_range(0, 99) < 4) rsp_calm = !rsp_calm;
            rsp_wait = rsp_calm ? 0 : $urandom_range(0, 10);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_tready <= (rsp_wait == 0);
      end
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic push_cmd(logic op, int sx, int sy, int ex, int ey, logic [31:0] colour);
      raster_cmd_type cmd;
      cmd.op      = op;
      cmd.start_x = sx[COORD_W-1:0];
      cmd.start_y = sy[COORD_W-1:0];
      cmd.end_x   = ex[COORD_W-1:0];
      cmd.end_y   = ey[COORD_W-1:0];
      cmd.colour  = colour;
      pending_cmds.push_back(cmd);
   endtask

   // Step items carry don't-care endpoint fields; fill them at random so the
   // block is seen to ignore them.
   task automatic push_steps(int count);
      repeat (count) push_cmd(clr_pkg::OP_STEP, $urandom, $urandom, $urandom, $urandom,
                              $urandom);
   endtask

   // Waits until every sent item has its result back and the block is quiet.
   task automatic wait_drained(int settle);
      while (pending_cmds.size() != 0 || drv_busy || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Writes both surface registers, one write per clock.
   task automatic set_surface(logic [SURF_W-1:0] w, logic [SURF_W-1:0] h);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= clr_pkg::CSR_SURFACE_WIDTH;
      csr_wdata <= w;
      surf_w = w;
      @(posedge clock);
      csr_index <= clr_pkg::CSR_SURFACE_HEIGHT;
      csr_wdata <= h;
      surf_h = h;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // A coordinate on one of the interesting boundaries: the ends of the
   // signed range, around zero, or around the surface edge.
   function automatic int edge_coord(int surf);
      case ($urandom_range(0, 6))
         0: return -4096;
         1: return -1;
         2: return 0;
         3: return 1;
         4: return 4095;
         5: return clamp_coord(surf - 1);
         default: return clamp_coord(surf);
      endcase
   endfunction

   // Random traffic for one surface setting. Most of it is a load followed by
   // enough steps to walk the line to its end and a little past, so the walk
   // runs through the clipping edges. Some lines are cut short by the next
   // load, and a few single items carry random content of either kind.
   task automatic queue_random_lines(int target);
      int made, sx, sy, ex, ey, hi_x, hi_y, span, steps;
      logic [31:0] colour;
      made = 0;
      while (made < target) begin
         if ($urandom_range(0, 99) < 6) begin
            push_cmd(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                     $urandom);
            made++;
         end else begin
            case ($urandom_range(0, 19))
               0, 1, 2: begin
                  // Full-range endpoints: long lines that are rarely finished.
                  sx = to_coord(COORD_W'($urandom));
                  sy = to_coord(COORD_W'($urandom));
                  ex = to_coord(COORD_W'($urandom));
                  ey = to_coord(COORD_W'($urandom));
               end
               3, 4: begin
                  sx = edge_coord(int'(surf_w));
                  sy = edge_coord(int'(surf_h));
                  ex = edge_coord(int'(surf_w));
                  ey = edge_coord(int'(surf_h));
               end
               default: begin
                  // Short lines around the surface so both sides of every edge
                  // get drawn.
                  hi_x = clamp_coord(int'(surf_w) + 6);
                  hi_y = clamp_coord(int'(surf_h) + 6);
                  sx = -6 + $urandom_range(0, hi_x + 6);
                  sy = -6 + $urandom_range(0, hi_y + 6);
                  ex = clamp_coord(sx + $urandom_range(0, 40) - 20);
                  ey = clamp_coord(sy + $urandom_range(0, 40) - 20);
               end
            endcase
            case ($urandom_range(0, 9))
               0: colour = 32'h0000_0000;
               1: colour = 32'hFFFF_FFFF;
               default: colour = $urandom;
            endcase
            push_cmd(clr_pkg::OP_LOAD, sx, sy, ex, ey, colour);
            span = (ex > sx) ? ex - sx : sx - ex;
            if (((ey > sy) ? ey - sy : sy - ey) > span) span = (ey > sy) ? ey - sy : sy - ey;
            if (span > 60) span = 60;
            if ($urandom_range(0, 99) < 75) steps = span + $urandom_range(0, 2);
            else steps = $urandom_range(0, span);
            push_steps(steps);
            made += 1 + steps;
         end
      end
   endtask

   logic [SURF_W-1:0] surf_widths  [NUM_SURFS];
   logic [SURF_W-1:0] surf_heights [NUM_SURFS];

   initial begin : stimulus
      // Surface sizes for the random phases: the smallest and largest legal
      // sizes, a zero width and a zero height that clip everything, the
      // all-ones register value, small odd sizes, the reset size and one random size.
      surf_widths  = '{13'd1, 13'd4096, 13'd0,   13'd100, 13'd8191, 13'd37, 13'd640, 13'd3};
      surf_heights = '{13'd1, 13'd4096, 13'd100, 13'd0,   13'd8191, 13'd23, 13'd480, 13'd2};
      surf_widths[7]  = SURF_W'($urandom_range(1, 4096));
      surf_heights[7] = SURF_W'($urandom_range(1, 4096));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part, on the surface size left by reset.
      // A step with no line loaded gives an idle result marked done.
      push_steps(1);
      // A line whose endpoints coincide has no pixels at all.
      push_cmd(clr_pkg::OP_LOAD, 10, 10, 10, 10, 32'h0000_0000);
      push_steps(1);
      // Shallow line with the minor axis falling, running off the right edge
      // of the surface, then one step past its end.
      push_cmd(clr_pkg::OP_LOAD, 637, 479, 642, 477, 32'hFFFF_FFFF);
      push_steps(6);
      // The full diagonal of the coordinate range, cut short by the next load.
      push_cmd(clr_pkg::OP_LOAD, -4096, 4095, 4095, -4096, 32'hA5A5_5A5A);
      push_steps(2);
      // Steep line with the minor axis falling that starts above the surface.
      push_cmd(clr_pkg::OP_LOAD, 3, -2, 1, 8, 32'h1234_5678);
      push_steps(4);
      // Steep line spanning the whole y range at the far left.
      push_cmd(clr_pkg::OP_LOAD, -4096, -4096, -4095, 4095, 32'h8000_0001);
      push_steps(2);
      // The last pixel inside the surface, at its bottom right corner.
      push_cmd(clr_pkg::OP_LOAD, 639, 479, 640, 479, 32'h7FFF_FFFE);
      push_steps(1);
      // One pixel at the origin.
      push_cmd(clr_pkg::OP_LOAD, 0, 0, 1, 0, 32'hFFFF_FFFF);
      push_steps(1);
      wait_drained(3);

      for (int s = 0; s < NUM_SURFS; s++) begin
         set_surface(surf_widths[s], surf_heights[s]);
         queue_random_lines(PHASE_ITEMS);
         wait_drained(3);
      end

      wait_drained(10);
      if (fail_count == 0 && expected_pixels.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
